// File: sv/imj_pkg.sv
// ----------------------------------------------------------------------------
// imj_pkg: shared types and constants for the interval merge join
// Command and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package imj_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned PosBitsDef    = 31;

  localparam int unsigned CmdBits    = 2;
  localparam int unsigned StatusBits = 2;

  typedef enum logic [CmdBits-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    ST_NONE  = 2'd0,
    ST_HIT   = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// File: sv/interval_merge_join.sv
// ----------------------------------------------------------------------------
// interval_merge_join: sort-merge join of token positions against intervals
// Holds a table of ascending intervals in one memory and walks a cursor
// through it with a single compare unit under a two-state sequencer.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata fields (low bit up)                     words
//  s_axis   in   cmd, first_pos, last_pos, token_pos           one command
//  m_axis   out  status, hit_first, hit_last, hit_position     one result
//
// Clear, load and unused commands are accepted in idle, then run in execute.
// A look-up stays in execute while the cursor steps past intervals ending before
// the token; the table memory's single read port gives one interval per cycle.
// Reset empties the table (entry count and cursor to zero); no clearing pass.
// A result waits in the output register; a stalled m_axis holds the
// sequencer in its execute cycle until the register frees up.
// ----------------------------------------------------------------------------
module interval_merge_join #(
  parameter int unsigned TableDepth = imj_pkg::TableDepthDef,
  parameter int unsigned PosBits    = imj_pkg::PosBitsDef,
  localparam int unsigned DataBits  =
    ((imj_pkg::CmdBits + 3 * PosBits + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd, first_pos, last_pos, token_pos, zero fill
  input  logic [DataBits-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status, hit_first, hit_last, hit_position, zero fill
  output logic [DataBits-1:0] m_axis_tdata
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned CB = imj_pkg::CmdBits;
  localparam int unsigned SB = imj_pkg::StatusBits;
  localparam int unsigned PadBits = DataBits - SB - 3 * PosBits;
  localparam logic [CW-1:0] DepthC = CW'(TableDepth);

  // table memory: {first, last}
  logic [2*PosBits-1:0] mem [TableDepth];
  logic [2*PosBits-1:0] rd_data_q;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [2*PosBits-1:0] wr_data;

  imj_pkg::state_e state_q, state_d;
  imj_pkg::cmd_e   cmd_q, cmd_cur;
  logic [PosBits-1:0] first_q, last_q, tok_q;
  logic [CW-1:0]      count_q, count_d, cursor_q, cursor_d, top;

  logic                 m_valid_q, m_valid_d;
  imj_pkg::status_e     m_status_q, res_status;
  logic [PosBits-1:0]   m_first_q, m_last_q, m_pos_q;
  logic [PosBits-1:0]   res_first, res_last, res_pos;
  logic                 out_free, out_load, accept;

  logic [PosBits-1:0]   ent_first, ent_last;

  assign s_axis_tready = (state_q == imj_pkg::S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign ent_first = rd_data_q[2*PosBits-1:PosBits];
  assign ent_last  = rd_data_q[PosBits-1:0];
  assign top       = count_q - CW'(1);
  assign cmd_cur   = (state_q == imj_pkg::S_IDLE) ?
                     imj_pkg::cmd_e'(s_axis_tdata[CB-1:0]) : cmd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cursor_d   = cursor_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[AW-1:0];
    wr_data    = {first_q, last_q};
    out_load   = 1'b0;
    res_status = imj_pkg::ST_NONE;
    res_first  = '0;
    res_last   = '0;
    res_pos    = '0;

    case (state_q)
      imj_pkg::S_IDLE: begin
        if (accept) begin
          state_d = imj_pkg::S_EXEC;
        end
      end
      imj_pkg::S_EXEC: begin
        case (cmd_q)
          imj_pkg::CMD_CLEAR: begin
            if (out_free) begin
              count_d  = '0;
              cursor_d = '0;
              out_load = 1'b1;
              state_d  = imj_pkg::S_IDLE;
            end
          end
          imj_pkg::CMD_LOAD: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = imj_pkg::S_IDLE;
              if (count_q == '0) begin
                wr_en   = 1'b1;
                count_d = CW'(1);
              end else if (first_q == ent_first) begin
                // same start: overwrite the newest entry's end
                wr_en   = 1'b1;
                wr_addr = top[AW-1:0];
              end else if (first_q < ent_first) begin
                res_status = imj_pkg::ST_ORDER;
              end else if (count_q == DepthC) begin
                res_status = imj_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
          end
          imj_pkg::CMD_LOOKUP: begin
            if ((cursor_q < count_q) && (ent_last < tok_q)) begin
              // advance past an interval that ends before the token
              cursor_d = cursor_q + CW'(1);
            end else if (out_free) begin
              out_load = 1'b1;
              state_d  = imj_pkg::S_IDLE;
              if ((cursor_q < count_q) && !(tok_q < ent_first)) begin
                res_status = imj_pkg::ST_HIT;
                res_first  = ent_first;
                res_last   = ent_last;
                res_pos    = tok_q;
              end
            end
          end
          default: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = imj_pkg::S_IDLE;
            end
          end
        endcase
      end
      default: state_d = imj_pkg::S_IDLE;
    endcase

    rd_addr   = (cmd_cur == imj_pkg::CMD_LOAD) ? top[AW-1:0] : cursor_d[AW-1:0];
    m_valid_d = out_load || (m_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= imj_pkg::S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= imj_pkg::cmd_e'(s_axis_tdata[CB-1:0]);
      first_q <= s_axis_tdata[CB +: PosBits];
      last_q  <= s_axis_tdata[CB+PosBits +: PosBits];
      tok_q   <= s_axis_tdata[CB+2*PosBits +: PosBits];
    end
    if (out_load) begin
      m_status_q <= res_status;
      m_first_q  <= res_first;
      m_last_q   <= res_last;
      m_pos_q    <= res_pos;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PadBits{1'b0}}, m_pos_q, m_last_q, m_first_q, m_status_q};

  a_cursor_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond entry count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond table depth");

  a_hit_encloses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == imj_pkg::ST_HIT) |->
      (m_first_q <= m_pos_q && m_pos_q <= m_last_q))
    else $error("hit position outside reported interval");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q != imj_pkg::ST_HIT) |->
      (m_first_q == '0 && m_last_q == '0 && m_pos_q == '0))
    else $error("non-hit result carries payload");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == imj_pkg::S_EXEC))
    else $error("result produced outside execute cycle");

endmodule
